[design/rhsd_pkg.sv]
// Package for the ramped H-bridge speed drive.
// Holds field widths, arithmetic constants, codes, FSM states and control structs.
// No dependencies.
package rhsd_pkg;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned DIR_W    = 2;
  localparam int unsigned SPEED_W  = 8;
  localparam int unsigned RATIO_W  = 10;
  localparam int unsigned STEP_W   = 8;
  localparam int unsigned GAIN_W   = 10;
  localparam int unsigned SCALE_W  = 8;
  localparam int unsigned CMP_W    = 9;
  localparam int unsigned DAC_W    = 8;
  localparam int unsigned DISP_W   = 9;
  localparam int unsigned REG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned MUL_W    = 18;
  localparam int unsigned PROD_W   = 2 * MUL_W;

  localparam logic [GAIN_W-1:0]  GAIN_RESET    = 10'd256;
  localparam logic [SCALE_W-1:0] DEFAULT_SCALE = 8'd15;
  localparam int                 DRIVE_LIMIT   = 80;
  localparam int unsigned        DISPLAY_MAX   = 511;
  localparam logic [17:0]        ROUND_FWD     = 18'd50;
  localparam logic [18:0]        ROUND_REV     = 19'd12800;
  // floor(x/100) = (x * RECIP_100) >> RECIP_100_SH for x < 2^16
  localparam logic [MUL_W-1:0]   RECIP_100     = 18'd83887;
  localparam int unsigned        RECIP_100_SH  = 23;
  // floor(x/3) = (x * RECIP_3) >> RECIP_3_SH for x < 512
  localparam logic [MUL_W-1:0]   RECIP_3       = 18'd171;
  localparam int unsigned        RECIP_3_SH    = 9;

  typedef enum logic [OP_W-1:0] {
    OP_GO    = 2'd0,
    OP_BRAKE = 2'd1,
    OP_STOP  = 2'd2,
    OP_HOLD  = 2'd3
  } op_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_FWD_GAIN    = 2'd0,
    REG_REV_GAIN    = 2'd1,
    REG_SPEED_SCALE = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RAMP,
    S_BRK_MUL,
    S_BRK_DIV,
    S_DISP,
    S_DIV,
    S_DRIVE,
    S_DONE
  } state_t;

  typedef enum logic [2:0] {
    MS_BRAKE,
    MS_RECIP3,
    MS_DISP,
    MS_RECIP100,
    MS_DRIVE
  } mul_sel_t;

  typedef struct packed {
    logic     in_ready;
    logic     ld_in;
    logic     upd_ramp;
    logic     ld_brake;
    logic     ld_disp;
    logic     ld_out;
    logic     mul_en;
    mul_sel_t mul_sel;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic brake_pos;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  fwd_gain;
    logic [GAIN_W-1:0]  rev_gain;
    logic [SCALE_W-1:0] scale;
  } cfg_t;

endpackage

[design/rhsd_if.sv]
// Channel interfaces for the ramped H-bridge speed drive: input, result, config.
// Valid/ready handshake; depends on rhsd_pkg for widths.
interface rhsd_in_if;
  logic                                valid;
  logic                                ready;
  logic [rhsd_pkg::OP_W-1:0]           op;
  logic signed [rhsd_pkg::DIR_W-1:0]   direction;
  logic signed [rhsd_pkg::SPEED_W-1:0] target_speed;
  logic [rhsd_pkg::RATIO_W-1:0]        brake_ratio;
  logic [rhsd_pkg::STEP_W-1:0]         stop_step;
  modport source (output valid, op, direction, target_speed, brake_ratio, stop_step,
                  input ready);
  modport sink (input valid, op, direction, target_speed, brake_ratio, stop_step,
                output ready);
endinterface

interface rhsd_out_if;
  logic                              valid;
  logic                              ready;
  logic [rhsd_pkg::CMP_W-1:0]        fwd_compare;
  logic [rhsd_pkg::CMP_W-1:0]        rev_compare;
  logic signed [rhsd_pkg::DAC_W-1:0] dac_level;
  logic [rhsd_pkg::DISP_W-1:0]       display_speed;
  modport source (output valid, fwd_compare, rev_compare, dac_level, display_speed,
                  input ready);
  modport sink (input valid, fwd_compare, rev_compare, dac_level, display_speed,
                output ready);
endinterface

interface rhsd_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [rhsd_pkg::REG_IDX_W-1:0]    reg_index;
  logic [rhsd_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, reg_index, data, input ready);
  modport sink (input valid, reg_index, data, output ready);
endinterface

[design/rhsd_cfg.sv]
// Configuration registers: forward gain, reverse gain and display scale.
// Depends on rhsd_pkg and rhsd_cfg_if.
module rhsd_cfg (
  input  logic             clk,
  input  logic             rst_n,
  rhsd_cfg_if.sink         cfg_ch,
  output rhsd_pkg::cfg_t   cfg
);

  logic [rhsd_pkg::GAIN_W-1:0]  fwd_gain_r, fwd_gain_nxt;
  logic [rhsd_pkg::GAIN_W-1:0]  rev_gain_r, rev_gain_nxt;
  logic [rhsd_pkg::SCALE_W-1:0] scale_r, scale_nxt;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    fwd_gain_nxt = fwd_gain_r;
    rev_gain_nxt = rev_gain_r;
    scale_nxt    = scale_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.reg_index)
        rhsd_pkg::REG_FWD_GAIN:    fwd_gain_nxt = cfg_ch.data;
        rhsd_pkg::REG_REV_GAIN:    rev_gain_nxt = cfg_ch.data;
        rhsd_pkg::REG_SPEED_SCALE: scale_nxt    = cfg_ch.data[rhsd_pkg::SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_gain_r <= rhsd_pkg::GAIN_RESET;
      rev_gain_r <= rhsd_pkg::GAIN_RESET;
      scale_r    <= '0;
    end else begin
      fwd_gain_r <= fwd_gain_nxt;
      rev_gain_r <= rev_gain_nxt;
      scale_r    <= scale_nxt;
    end
  end

  assign cfg.fwd_gain = fwd_gain_r;
  assign cfg.rev_gain = rev_gain_r;
  assign cfg.scale    = (scale_r == '0) ? rhsd_pkg::DEFAULT_SCALE : scale_r;

endmodule

[design/rhsd_mul.sv]
// Shared signed multiplier with registered product and load enable.
// Depends on rhsd_pkg.
module rhsd_mul (
  input  logic                                 clk,
  input  logic                                 en,
  input  logic signed [rhsd_pkg::MUL_W-1:0]    a,
  input  logic signed [rhsd_pkg::MUL_W-1:0]    b,
  output logic signed [rhsd_pkg::PROD_W-1:0]   p_r
);

  logic signed [rhsd_pkg::PROD_W-1:0] p_nxt;

  assign p_nxt = en ? a * b : p_r;

  always_ff @(posedge clk) begin
    p_r <= p_nxt;
  end

endmodule

[design/rhsd_seq.sv]
// Sequencer for one transaction: ramp update, optional brake divide, display
// divide, drive scaling, result hand-off. Depends on rhsd_pkg.
module rhsd_seq (
  input  logic                clk,
  input  logic                rst_n,
  input  rhsd_pkg::status_t   st,
  output rhsd_pkg::ctrl_t     ctl,
  output rhsd_pkg::state_t    state
);

  rhsd_pkg::state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rhsd_pkg::S_IDLE:    if (st.in_valid) state_nxt = rhsd_pkg::S_RAMP;
      rhsd_pkg::S_RAMP:    state_nxt = st.brake_pos ? rhsd_pkg::S_BRK_MUL : rhsd_pkg::S_DISP;
      rhsd_pkg::S_BRK_MUL: state_nxt = rhsd_pkg::S_BRK_DIV;
      rhsd_pkg::S_BRK_DIV: state_nxt = rhsd_pkg::S_DISP;
      rhsd_pkg::S_DISP:    state_nxt = rhsd_pkg::S_DIV;
      rhsd_pkg::S_DIV:     state_nxt = rhsd_pkg::S_DRIVE;
      rhsd_pkg::S_DRIVE:   state_nxt = rhsd_pkg::S_DONE;
      rhsd_pkg::S_DONE:    if (st.out_free) state_nxt = rhsd_pkg::S_IDLE;
      default:             state_nxt = rhsd_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    ctl = '0;
    ctl.mul_sel = rhsd_pkg::MS_BRAKE;
    unique case (state_r)
      rhsd_pkg::S_IDLE: begin
        ctl.in_ready = 1'b1;
        ctl.ld_in    = st.in_valid;
      end
      rhsd_pkg::S_RAMP: begin
        ctl.upd_ramp = 1'b1;
        ctl.mul_en   = 1'b1;
        ctl.mul_sel  = rhsd_pkg::MS_BRAKE;
      end
      rhsd_pkg::S_BRK_MUL: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = rhsd_pkg::MS_RECIP3;
      end
      rhsd_pkg::S_BRK_DIV: begin
        ctl.ld_brake = 1'b1;
      end
      rhsd_pkg::S_DISP: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = rhsd_pkg::MS_DISP;
      end
      rhsd_pkg::S_DIV: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = rhsd_pkg::MS_RECIP100;
      end
      rhsd_pkg::S_DRIVE: begin
        ctl.ld_disp = 1'b1;
        ctl.mul_en  = 1'b1;
        ctl.mul_sel = rhsd_pkg::MS_DRIVE;
      end
      rhsd_pkg::S_DONE: begin
        ctl.ld_out = st.out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rhsd_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign state = state_r;

endmodule

[design/ramped_hbridge_speed_drive.sv]
// Ramped H-bridge speed drive, top level.
// A transaction runs through states RAMP, DISP, DIV, DRIVE and DONE to its result
// (BRK_MUL and BRK_DIV follow RAMP for a brake from a positive ramp), one sequencer
// step per use of the shared multiplier; DONE holds while an earlier result waits.
// The result register frees the sequencer while a result waits to be taken.
// Reset (synchronous, rst_n low): ramp 0, gains 256, scale 0, channels empty.
module ramped_hbridge_speed_drive (
  input  logic        clk,
  input  logic        rst_n,
  rhsd_in_if.sink     in_ch,
  rhsd_out_if.source  out_ch,
  rhsd_cfg_if.sink    cfg_ch
);

  localparam int unsigned MW = rhsd_pkg::MUL_W;

  rhsd_pkg::cfg_t    cfg;
  rhsd_pkg::ctrl_t   ctl;
  rhsd_pkg::status_t st;
  rhsd_pkg::state_t  state;

  logic signed [MW-1:0]                   mul_a, mul_b;
  logic signed [rhsd_pkg::PROD_W-1:0]     p_r;

  rhsd_pkg::op_t                          op_r;
  logic [rhsd_pkg::DIR_W-1:0]             dir_r;
  logic signed [rhsd_pkg::SPEED_W-1:0]    target_r;
  logic [rhsd_pkg::RATIO_W-1:0]           ratio_r;
  logic [rhsd_pkg::STEP_W-1:0]            step_r;

  logic signed [7:0] ramp_r, ramp_nxt;
  logic signed [8:0] spd_r, spd_nxt;
  logic [8:0]        disp_r, disp_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [8:0]        fwd_r, rev_r, disp_out_r;
  logic signed [7:0] dac_r;

  logic              dir_pos, dir_neg, dir_zero;
  logic signed [9:0] stop_diff;
  logic signed [7:0] ramp_upd;
  logic signed [8:0] spd_upd;
  logic signed [7:0] clamp_c;
  logic [7:0]        brake_q;
  logic signed [17:0] fsum;
  logic [16:0]       fabs;
  logic [18:0]       rsum;
  logic [16:0]       div_num;
  logic [11:0]       disp_q;
  logic signed [17:0] drv_p;
  logic [16:0]       drv_abs;
  logic [8:0]        drv_mag;
  logic              d_pos, d_neg;
  logic [rhsd_pkg::GAIN_W-1:0] gain_sel;

  rhsd_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  rhsd_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .ctl   (ctl),
    .state (state)
  );

  rhsd_mul u_mul (
    .clk (clk),
    .en  (ctl.mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (p_r)
  );

  assign in_ch.ready  = ctl.in_ready;
  assign st.in_valid  = in_ch.valid;
  assign st.brake_pos = (op_r == rhsd_pkg::OP_BRAKE) && (ramp_r > 8'sd0);
  assign st.out_free  = !out_valid_r || out_ch.ready;

  assign dir_pos  = (dir_r == 2'b01);
  assign dir_zero = (dir_r == 2'b00);
  assign dir_neg  = dir_r[1];

  // transaction capture
  always_ff @(posedge clk) begin
    if (ctl.ld_in) begin
      op_r     <= rhsd_pkg::op_t'(in_ch.op);
      dir_r    <= in_ch.direction;
      target_r <= in_ch.target_speed;
      ratio_r  <= in_ch.brake_ratio;
      step_r   <= in_ch.stop_step;
    end
  end

  // ramp update
  assign stop_diff = {{2{ramp_r[7]}}, ramp_r} - {2'b00, step_r};

  always_comb begin
    ramp_upd = ramp_r;
    spd_upd  = {ramp_r[7], ramp_r};
    unique case (op_r)
      rhsd_pkg::OP_GO: begin
        if (target_r > ramp_r) begin
          ramp_upd = ramp_r + 8'sd1;
        end else if (target_r < ramp_r) begin
          ramp_upd = ramp_r - 8'sd1;
        end
        if (dir_zero) begin
          ramp_upd = '0;
        end
        spd_upd = {ramp_upd[7], ramp_upd};
      end
      rhsd_pkg::OP_BRAKE: begin
        if (ramp_r > 8'sd0) begin
          ramp_upd = ramp_r - 8'sd1;
          spd_upd  = spd_r;
        end else begin
          ramp_upd = '0;
          spd_upd  = '0;
        end
      end
      rhsd_pkg::OP_STOP: begin
        ramp_upd = stop_diff[9] ? 8'sd0 : stop_diff[7:0];
        spd_upd  = {ramp_upd[7], ramp_upd};
      end
      rhsd_pkg::OP_HOLD: begin
        ramp_upd = ramp_r;
        spd_upd  = {ramp_r[7], ramp_r};
      end
      default: ;
    endcase
  end

  assign brake_q = p_r[rhsd_pkg::RECIP_3_SH +: 8];

  always_comb begin
    ramp_nxt = ramp_r;
    spd_nxt  = spd_r;
    if (ctl.upd_ramp) begin
      ramp_nxt = ramp_upd;
      spd_nxt  = spd_upd;
    end else if (ctl.ld_brake) begin
      spd_nxt = 9'sd0 - $signed({1'b0, brake_q});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ramp_r <= '0;
    end else begin
      ramp_r <= ramp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    spd_r  <= spd_nxt;
    disp_r <= disp_nxt;
  end

  // clamp to drive limit
  always_comb begin
    if (spd_r > 9'(rhsd_pkg::DRIVE_LIMIT)) begin
      clamp_c = 8'(rhsd_pkg::DRIVE_LIMIT);
    end else if (spd_r < -9'(rhsd_pkg::DRIVE_LIMIT)) begin
      clamp_c = -8'(rhsd_pkg::DRIVE_LIMIT);
    end else begin
      clamp_c = spd_r[7:0];
    end
  end

  // display numerator
  assign fsum    = p_r[17:0] + $signed(rhsd_pkg::ROUND_FWD);
  assign fabs    = fsum[17] ? 17'(-fsum) : fsum[16:0];
  assign rsum    = p_r[18:0] + rhsd_pkg::ROUND_REV;
  assign div_num = dir_pos ? fabs : {6'b0, rsum[18:8]};

  assign disp_q   = p_r[rhsd_pkg::RECIP_100_SH +: 12];
  assign disp_nxt = ctl.ld_disp
                    ? ((disp_q > 12'(rhsd_pkg::DISPLAY_MAX)) ? 9'(rhsd_pkg::DISPLAY_MAX)
                                                             : disp_q[8:0])
                    : disp_r;

  assign gain_sel = dir_pos ? cfg.fwd_gain : cfg.rev_gain;

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (ctl.mul_sel)
      rhsd_pkg::MS_BRAKE: begin
        mul_a = {{(MW-8){ramp_r[7]}}, ramp_r};
        mul_b = {{(MW-rhsd_pkg::RATIO_W){1'b0}}, ratio_r};
      end
      rhsd_pkg::MS_RECIP3: begin
        mul_a = {8'b0, p_r[17:8]};
        mul_b = rhsd_pkg::RECIP_3;
      end
      rhsd_pkg::MS_DISP: begin
        mul_a = {{(MW-rhsd_pkg::SCALE_W){1'b0}}, cfg.scale};
        mul_b = dir_pos ? {{(MW-9){spd_r[8]}}, spd_r}
                        : {{(MW-rhsd_pkg::GAIN_W){1'b0}}, cfg.rev_gain};
      end
      rhsd_pkg::MS_RECIP100: begin
        mul_a = {1'b0, div_num};
        mul_b = rhsd_pkg::RECIP_100;
      end
      rhsd_pkg::MS_DRIVE: begin
        mul_a = {{(MW-8){clamp_c[7]}}, clamp_c};
        mul_b = {{(MW-rhsd_pkg::GAIN_W){1'b0}}, gain_sel};
      end
      default: ;
    endcase
  end

  // drive split
  assign drv_p   = p_r[17:0];
  assign drv_abs = drv_p[17] ? 17'(-drv_p) : drv_p[16:0];
  assign drv_mag = drv_abs[16:8];
  assign d_pos   = (dir_pos && clamp_c > 8'sd0) || (dir_neg && clamp_c < 8'sd0);
  assign d_neg   = (dir_pos && clamp_c < 8'sd0) || (dir_neg && clamp_c > 8'sd0);

  // result register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.ld_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_out) begin
      fwd_r      <= d_pos ? drv_mag : 9'd0;
      rev_r      <= d_neg ? drv_mag : 9'd0;
      dac_r      <= clamp_c;
      disp_out_r <= disp_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.fwd_compare   = fwd_r;
  assign out_ch.rev_compare   = rev_r;
  assign out_ch.dac_level     = dac_r;
  assign out_ch.display_speed = disp_out_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input accepted while a transaction is in progress");

  a_dac_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.dac_level <= 8'sd80 && out_ch.dac_level >= -8'sd80))
    else $error("dac level outside drive limit");

  a_one_side_driven: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.fwd_compare == '0 || out_ch.rev_compare == '0))
    else $error("forward and reverse compare both active");

  a_product_held: assert property (@(posedge clk) disable iff (!rst_n)
    (state == rhsd_pkg::S_DONE && $past(state == rhsd_pkg::S_DONE)) |-> $stable(p_r))
    else $error("shared product changed while waiting to deliver");

endmodule

[bench/testbench.sv]
// Testbench for ramped_hbridge_speed_drive: drives go/brake/stop/hold commands and register writes,
// predicts each drive result and checks it in order. Random idling on both channels.
// Depends on rhsd_pkg, the rhsd channel interfaces and the ramped_hbridge_speed_drive top.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 11;
  localparam int DRAIN_CYCLES   = 12;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int HOLD_CYCLES    = 400;
  localparam logic [rhsd_pkg::REG_IDX_W-1:0] REG_NONE = 2'd3;

  typedef struct {
    logic [rhsd_pkg::CMP_W-1:0]        fwd;
    logic [rhsd_pkg::CMP_W-1:0]        rev;
    logic signed [rhsd_pkg::DAC_W-1:0] dac;
    logic [rhsd_pkg::DISP_W-1:0]       disp;
  } drive_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  rhsd_in_if  in_ch ();
  rhsd_out_if out_ch ();
  rhsd_cfg_if cfg_ch ();

  ramped_hbridge_speed_drive i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // drive model state and registers
  int ramp_now = 0;
  logic [rhsd_pkg::GAIN_W-1:0]  gain_fwd = rhsd_pkg::GAIN_RESET;
  logic [rhsd_pkg::GAIN_W-1:0]  gain_rev = rhsd_pkg::GAIN_RESET;
  logic [rhsd_pkg::SCALE_W-1:0] disp_scale = '0;

  drive_result_t drive_results_due[$];
  int mismatch_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_left = 0;
  int hold_requests = 0;
  int hold_served = 0;
  int quiet_cycles = 0;

  always #(CLK_PERIOD / 2) clk = ~clk;

  function automatic drive_result_t next_drive(rhsd_pkg::op_t op,
                                               logic signed [rhsd_pkg::DIR_W-1:0] dir_raw,
                                               logic signed [rhsd_pkg::SPEED_W-1:0] target,
                                               logic [rhsd_pkg::RATIO_W-1:0] ratio,
                                               logic [rhsd_pkg::STEP_W-1:0] step);
    int dir_i, tgt, spd, scale, disp, clamped, gain, drv, fwd_i, rev_i;
    drive_result_t r;
    dir_i = int'(dir_raw);
    tgt = int'(target);
    if (dir_i < -1) dir_i = -1;
    case (op)
      rhsd_pkg::OP_GO: begin
        if (tgt > ramp_now) ramp_now++;
        else if (tgt < ramp_now) ramp_now--;
        if (dir_i == 0) ramp_now = 0;
        spd = ramp_now;
      end
      rhsd_pkg::OP_BRAKE: begin
        if (ramp_now > 0) begin
          spd = -((ramp_now * int'(ratio)) / 768);
          ramp_now--;
        end else begin
          spd = 0;
          ramp_now = 0;
        end
      end
      rhsd_pkg::OP_STOP: begin
        ramp_now = ramp_now - int'(step);
        if (ramp_now < 0) ramp_now = 0;
        spd = ramp_now;
      end
      default: spd = ramp_now;
    endcase

    scale = (disp_scale != '0) ? int'(disp_scale) : int'(rhsd_pkg::DEFAULT_SCALE);
    if (dir_i > 0) begin
      disp = (scale * spd + 50) / 100;
      if (disp < 0) disp = -disp;
      gain = int'(gain_fwd);
    end else begin
      disp = (scale * int'(gain_rev) + 12800) / 25600;
      gain = int'(gain_rev);
    end
    if (disp > int'(rhsd_pkg::DISPLAY_MAX)) disp = int'(rhsd_pkg::DISPLAY_MAX);

    clamped = spd;
    if (clamped > rhsd_pkg::DRIVE_LIMIT) clamped = rhsd_pkg::DRIVE_LIMIT;
    if (clamped < -rhsd_pkg::DRIVE_LIMIT) clamped = -rhsd_pkg::DRIVE_LIMIT;
    drv = (dir_i * clamped * gain) / 256;

    fwd_i  = (drv > 0) ? drv : 0;
    rev_i  = (drv < 0) ? -drv : 0;
    r.fwd  = fwd_i[rhsd_pkg::CMP_W-1:0];
    r.rev  = rev_i[rhsd_pkg::CMP_W-1:0];
    r.dac  = clamped[rhsd_pkg::DAC_W-1:0];
    r.disp = disp[rhsd_pkg::DISP_W-1:0];
    return r;
  endfunction

  function automatic void check_field(string fname, logic signed [15:0] want,
                                      logic signed [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
      mismatch_count++;
    end
  endfunction

  task automatic send_cmd(rhsd_pkg::op_t op, int dir, int target, int ratio, int step);
    logic signed [rhsd_pkg::DIR_W-1:0]   dir_f;
    logic signed [rhsd_pkg::SPEED_W-1:0] tgt_f;
    logic [rhsd_pkg::RATIO_W-1:0]        ratio_f;
    logic [rhsd_pkg::STEP_W-1:0]         step_f;
    dir_f   = dir[rhsd_pkg::DIR_W-1:0];
    tgt_f   = target[rhsd_pkg::SPEED_W-1:0];
    ratio_f = ratio[rhsd_pkg::RATIO_W-1:0];
    step_f  = step[rhsd_pkg::STEP_W-1:0];
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid        <= 1'b1;
    in_ch.op           <= op;
    in_ch.direction    <= dir_f;
    in_ch.target_speed <= tgt_f;
    in_ch.brake_ratio  <= ratio_f;
    in_ch.stop_step    <= step_f;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    drive_results_due.push_back(next_drive(op, dir_f, tgt_f, ratio_f, step_f));
  endtask

  task automatic write_reg(logic [rhsd_pkg::REG_IDX_W-1:0] idx,
                           logic [rhsd_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.data      <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    case (idx)
      rhsd_pkg::REG_FWD_GAIN:    gain_fwd = value;
      rhsd_pkg::REG_REV_GAIN:    gain_rev = value;
      rhsd_pkg::REG_SPEED_SCALE: disp_scale = value[rhsd_pkg::SCALE_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (drive_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // reset configuration: gains 256, scale 0
  task automatic test_directed_cases();
    send_cmd(rhsd_pkg::OP_HOLD,  1,    0,    0,   0);
    send_cmd(rhsd_pkg::OP_BRAKE, 1,    0, 1023,   0);
    send_cmd(rhsd_pkg::OP_STOP,  1,    0,    0, 255);
    send_cmd(rhsd_pkg::OP_GO,    1,  127,    0,   0);
    send_cmd(rhsd_pkg::OP_GO,    1,  127,    0,   0);
    send_cmd(rhsd_pkg::OP_GO,    0,  127,    0,   0);
    repeat (3) send_cmd(rhsd_pkg::OP_GO, 1, 127, 0, 0);
    send_cmd(rhsd_pkg::OP_GO,    1,    3,    0,   0);
    send_cmd(rhsd_pkg::OP_BRAKE, 1,    0, 1023,   0);
    send_cmd(rhsd_pkg::OP_BRAKE, -1,   0,    0,   0);
    send_cmd(rhsd_pkg::OP_STOP,  1,    0,    0,   0);
    send_cmd(rhsd_pkg::OP_STOP,  -2,   0,    0,   1);
    repeat (3) send_cmd(rhsd_pkg::OP_GO, -1, -128, 0, 0);
    send_cmd(rhsd_pkg::OP_GO,    -2, -128,   0,   0);
    send_cmd(rhsd_pkg::OP_HOLD,  -1,   0,    0,   0);
    send_cmd(rhsd_pkg::OP_BRAKE, -1,   0,  512,   0);
    send_cmd(rhsd_pkg::OP_GO,    1, -128,    0,   0);
    send_cmd(rhsd_pkg::OP_STOP,  1,    0,    0, 255);
  endtask

  task automatic test_gain_extremes();
    wait_drained();
    write_reg(rhsd_pkg::REG_FWD_GAIN, 10'h3FF);
    write_reg(rhsd_pkg::REG_REV_GAIN, 10'h3FF);
    write_reg(rhsd_pkg::REG_SPEED_SCALE, 10'h3FF);
    write_reg(REG_NONE, 10'h000);
    repeat (130) send_cmd(rhsd_pkg::OP_GO, 1, 127, 0, 0);
    repeat (3) send_cmd(rhsd_pkg::OP_BRAKE, 1, 0, 1023, 0);
    repeat (260) send_cmd(rhsd_pkg::OP_GO, -1, -128, 1023, 255);
    send_cmd(rhsd_pkg::OP_BRAKE, -2, 0, 1023, 0);
  endtask

  task automatic test_random_traffic(int fwd, int rev, int scale, int sidle, int ridle,
                                     int n_items);
    int sent, run_len, pick, dir, tgt;
    wait_drained();
    write_reg(rhsd_pkg::REG_FWD_GAIN, fwd[rhsd_pkg::CFG_DATA_W-1:0]);
    write_reg(rhsd_pkg::REG_REV_GAIN, rev[rhsd_pkg::CFG_DATA_W-1:0]);
    write_reg(rhsd_pkg::REG_SPEED_SCALE, scale[rhsd_pkg::CFG_DATA_W-1:0]);
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if ($urandom_range(9) == 0) dir = -2;
      else dir = $urandom_range(1) ? 1 : -1;
      if (pick < 55) begin
        tgt = $urandom;
        run_len = ($urandom_range(3) == 0) ? $urandom_range(80, 160) : $urandom_range(1, 40);
        repeat (run_len) send_cmd(rhsd_pkg::OP_GO, dir, tgt, $urandom, $urandom);
        sent += run_len;
      end else if (pick < 75) begin
        run_len = $urandom_range(1, 8);
        repeat (run_len) send_cmd(rhsd_pkg::OP_BRAKE, dir, $urandom, $urandom, $urandom);
        sent += run_len;
      end else if (pick < 88) begin
        send_cmd(rhsd_pkg::OP_STOP, dir, $urandom, $urandom,
                 $urandom_range(1) ? $urandom_range(15) : $urandom);
        sent++;
      end else begin
        send_cmd(rhsd_pkg::op_t'($urandom_range(3)), $urandom, $urandom, $urandom,
                 $urandom);
        sent++;
      end
    end
  endtask

  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(posedge clk);
    hold_requests++;
    repeat (30) send_cmd(rhsd_pkg::OP_GO, 1, $urandom, $urandom, $urandom);
    repeat (10) send_cmd(rhsd_pkg::op_t'($urandom_range(3)), $urandom, $urandom, $urandom,
                         $urandom);
    wait_drained();
    repeat (20) send_cmd(rhsd_pkg::op_t'($urandom_range(3)), $urandom, $urandom, $urandom,
                         $urandom);
  endtask

  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      stall_left = HOLD_CYCLES;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin : result_check
    drive_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (drive_results_due.size() == 0) begin
        $display("%0t: result transaction with nothing expected, fwd %0d rev %0d dac %0d disp %0d",
                 $time, out_ch.fwd_compare, out_ch.rev_compare, out_ch.dac_level,
                 out_ch.display_speed);
        mismatch_count++;
      end else begin
        want = drive_results_due.pop_front();
        check_field("fwd_compare", 16'(want.fwd), 16'(out_ch.fwd_compare));
        check_field("rev_compare", 16'(want.rev), 16'(out_ch.rev_compare));
        check_field("dac_level", 16'(want.dac), 16'(out_ch.dac_level));
        check_field("display_speed", 16'(want.disp), 16'(out_ch.display_speed));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: timeout, no transaction for %0d cycles", $time, quiet_cycles);
      $display("*** FAILED ***");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    in_ch.valid        = 1'b0;
    in_ch.op           = rhsd_pkg::OP_GO;
    in_ch.direction    = '0;
    in_ch.target_speed = '0;
    in_ch.brake_ratio  = '0;
    in_ch.stop_step    = '0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.reg_index   = rhsd_pkg::REG_FWD_GAIN;
    cfg_ch.data        = '0;
    out_ch.ready       = 1'b0;
    send_idle_pct      = 23;
    recv_idle_pct      = 54;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_cases();
    test_gain_extremes();
    test_random_traffic(0, 0, 1, 23, 54, 280);
    test_random_traffic($urandom, $urandom, $urandom, 54, 23, 280);
    test_random_traffic(256, 128, 0, 0, 0, 280);
    test_output_backpressure();
    wait_drained();

    if (mismatch_count == 0 && drive_results_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
